// ===== hw/rtl/mfd_pkg.sv =====
// Shared types, constants and functions of the 3x3 median frame difference unit.
// No dependencies.
package mfd_pkg;
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = 12;
   localparam int WCFG_W = 11;
   localparam int PIX_W = 48;
   localparam int DIFF_W = 16;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam logic [16:0] DIFF_GAIN = 17'd40960;
   localparam logic [8:0] DIFF_DIV = 9'd255;
   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // One result request: which window columns and rows to use, plus tags.
   typedef struct packed {
      logic             valid;
      logic             col_end;
      logic             row_last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             frame_end;
   } slot_type;

   typedef struct packed {
      logic [DIFF_W-1:0] d2;
      logic [DIFF_W-1:0] d1;
      logic [DIFF_W-1:0] d0;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              frame_end;
   } result_type;

   function automatic logic [7:0] med3_mid(input logic [7:0] a, b, c);
      logic [7:0] lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (c < lo) ? lo : ((c > hi) ? hi : c);
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, b, c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, b, c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction
endpackage

// ===== hw/rtl/mfd_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module mfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== hw/rtl/mfd_lane.sv =====
// One channel lane: 3x3 median of new and old samples, absolute difference, gain.
// Depends on mfd_pkg. Three pipeline stages.
module mfd_lane (
   input  logic         clock,
   input  logic         en,
   input  logic [71:0]  win_new,
   input  logic [71:0]  win_old,
   output logic [mfd_pkg::DIFF_W-1:0] diff
);
   import mfd_pkg::*;

   logic [7:0] mn_ff, mo_ff, mn_in, mo_in;
   logic [7:0] ad_ff, ad_in;
   logic [DIFF_W-1:0] diff_ff;
   logic [23:0] num;
   logic [31:0] q_est;
   logic [15:0] q;
   logic [23:0] rem;

   function automatic logic [7:0] med9(input logic [71:0] w);
      logic [7:0] r0, r1, r2;
      // Classic max-of-mins / med-of-meds / min-of-maxes over three triples.
      r0 = max3(min3(w[7:0], w[15:8], w[23:16]), min3(w[31:24], w[39:32], w[47:40]),
                min3(w[55:48], w[63:56], w[71:64]));
      r1 = med3_mid(med3_mid(w[7:0], w[15:8], w[23:16]),
                    med3_mid(w[31:24], w[39:32], w[47:40]),
                    med3_mid(w[55:48], w[63:56], w[71:64]));
      r2 = min3(max3(w[7:0], w[15:8], w[23:16]), max3(w[31:24], w[39:32], w[47:40]),
                max3(w[55:48], w[63:56], w[71:64]));
      return med3_mid(r0, r1, r2);
   endfunction

   assign mn_in = med9(win_new);
   assign mo_in = med9(win_old);
   assign ad_in = (mn_ff > mo_ff) ? mn_ff - mo_ff : mo_ff - mn_ff;

   // d*40960/255: d*40960 fits 24 bits; divide by 255 via 257/65536 scaled
   // reciprocal with a final correction.
   always_comb begin
      num = 24'(ad_ff) * 24'(DIFF_GAIN);
      q_est = (32'(num) * 32'd257) >> 16;
      q = q_est[15:0];
      rem = num - 24'(q) * 24'(DIFF_DIV);
      if (rem >= 24'(DIFF_DIV)) begin
         q = q + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mn_ff <= mn_in;
         mo_ff <= mo_in;
         ad_ff <= ad_in;
         diff_ff <= q;
      end
   end
   assign diff = diff_ff;
endmodule

// ===== hw/rtl/median3x3_frame_difference_unit.sv =====
// Top level of the 3x3 median frame difference unit.
// Depends on mfd_pkg, mfd_ram and mfd_lane.
// Throughput: one pixel per cycle. A pixel that releases several results (row end, last
// row) holds the input until its last result issues, since the three channel lanes take
// one result per cycle; a result queue whose 8 entries are all filled or reserved by
// results in flight also holds the input.
// Reset is synchronous; the line store is not cleared (unwritten reads unused).
module median3x3_frame_difference_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // new_ch0, new_ch1, new_ch2, old_ch0, old_ch1, old_ch2
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // diff_ch0, diff_ch1, diff_ch2, out_row, out_col, pad
   output logic [71:0] rsp_tdata,
   // frame_end
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);
   import mfd_pkg::*;

   logic [WCFG_W-1:0] width_ff;
   logic [ROW_W-1:0]  height_ff;
   logic [COL_W:0]    w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;

   // Stage A: accept, read line store. Stage B: window and result slots.
   logic accept, a_adv, b_busy, b_free, multi, room, issuing;
   logic a_v_ff, byp_ff;
   logic [PIX_W-1:0] a_cur_ff, byp_data_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic [PIX_W-1:0] ra, rb, ra_eff;

   logic [PIX_W-1:0] win_ff [9];
   slot_type slots_ff [4];
   logic [3:0] vmask;
   logic [1:0] sel;
   slot_type s;
   logic [FIFO_AW:0] fifo_cnt_ff;
   logic [2:0] inflight_ff;

   assign w_eff = (width_ff == '0) ? (COL_W+1)'(1) :
                  (width_ff > WCFG_W'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) :
                  (COL_W+1)'(width_ff);
   assign h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;

   assign vmask = {slots_ff[3].valid, slots_ff[2].valid, slots_ff[1].valid,
                   slots_ff[0].valid};
   assign b_busy = vmask != 4'd0;
   assign multi = (vmask & (vmask - 4'd1)) != 4'd0;

   // A slot issues only when the result queue has room for everything in flight.
   assign room = ((FIFO_AW+2)'(fifo_cnt_ff) + (FIFO_AW+2)'(inflight_ff))
                 < (FIFO_AW+2)'(FIFO_DEPTH);
   assign issuing = b_busy && room;
   assign b_free = !b_busy || (issuing && !multi);
   assign a_adv = a_v_ff && b_free;
   assign req_tready = !a_v_ff || b_free;
   assign accept = req_tvalid && req_tready;

   mfd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
      .clock, .wr_en(accept), .wr_addr(col_ff), .wr_data(req_tdata),
      .rd_en(accept), .rd_addr(col_ff), .rd_data(rb));
   mfd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
      .clock, .wr_en(a_adv), .wr_addr(a_col_ff), .wr_data(rb),
      .rd_en(accept), .rd_addr(col_ff), .rd_data(ra));

   // With a one pixel line, the older line is written at the same edge that the
   // next pixel reads it, so that read takes the value being written instead.
   assign ra_eff = byp_ff ? byp_data_ff : ra;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WCFG_W'(640);
         height_ff <= ROW_W'(480);
         col_ff <= '0;
         row_ff <= '0;
         a_v_ff <= 1'b0;
      end else begin
         if (accept) a_v_ff <= 1'b1;
         else if (a_adv) a_v_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) width_ff <= csr_wdata[WCFG_W-1:0];
            else height_ff <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            if ((COL_W+1)'(col_ff) + (COL_W+1)'(1) >= w_eff) begin
               col_ff <= '0;
               row_ff <= (row_ff + ROW_W'(1) >= h_eff) ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cur_ff <= req_tdata;
         a_col_ff <= ((COL_W+1)'(col_ff) >= w_eff) ? '0 : col_ff;
         a_row_ff <= (row_ff >= h_eff) ? '0 : row_ff;
         byp_ff <= a_adv && (a_col_ff == col_ff);
         byp_data_ff <= rb;
      end
   end

   logic [PIX_W-1:0] top, mid, bot;
   always_comb begin
      if (a_row_ff == '0) begin
         top = a_cur_ff; mid = a_cur_ff; bot = a_cur_ff;
      end else begin
         top = (a_row_ff >= ROW_W'(2)) ? ra_eff : rb;
         mid = rb;
         bot = a_cur_ff;
      end
   end

   logic last_col, last_row;
   assign last_col = ((COL_W+1)'(a_col_ff) == w_eff - (COL_W+1)'(1));
   assign last_row = (a_row_ff == h_eff - ROW_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         for (int i = 0; i < 4; i++) slots_ff[i] <= '0;
      end else if (a_adv) begin
         if (a_col_ff == '0) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3] <= top; win_ff[i*3+1] <= mid; win_ff[i*3+2] <= bot;
            end
         end else begin
            for (int i = 0; i < 6; i++) win_ff[i] <= win_ff[i+3];
            win_ff[6] <= top; win_ff[7] <= mid; win_ff[8] <= bot;
         end
         slots_ff[0] <= '{valid: (a_row_ff != '0) && (a_col_ff != '0), col_end: 1'b0,
            row_last: 1'b0, row: a_row_ff - ROW_W'(1), col: a_col_ff - COL_W'(1),
            frame_end: 1'b0};
         slots_ff[1] <= '{valid: (a_row_ff != '0) && last_col, col_end: 1'b1,
            row_last: 1'b0, row: a_row_ff - ROW_W'(1), col: a_col_ff,
            frame_end: 1'b0};
         slots_ff[2] <= '{valid: last_row && (a_col_ff != '0), col_end: 1'b0,
            row_last: 1'b1, row: a_row_ff, col: a_col_ff - COL_W'(1),
            frame_end: 1'b0};
         slots_ff[3] <= '{valid: last_row && last_col, col_end: 1'b1,
            row_last: 1'b1, row: a_row_ff, col: a_col_ff, frame_end: 1'b1};
      end else if (issuing) begin
         slots_ff[sel].valid <= 1'b0;
      end
   end

   // The lowest pending slot issues first, which keeps the raster order.
   always_comb begin
      sel = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (slots_ff[i].valid) sel = 2'(i);
      end
   end
   assign s = slots_ff[sel];

   // Select the neighborhood for the current slot.
   logic [PIX_W-1:0] nb [9];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb[i*3+j] = win_ff[(s.col_end ? ((i == 0) ? 1 : 2) : i) * 3 +
                               (s.row_last ? ((j == 0) ? 1 : 2) : j)];
         end
      end
   end

   logic [71:0] wn [3], wo [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int p = 0; p < 9; p++) begin
            wn[k][p*8 +: 8] = nb[p][k*8 +: 8];
            wo[k][p*8 +: 8] = nb[p][(k+3)*8 +: 8];
         end
      end
   end

   logic [DIFF_W-1:0] dl [3];
   for (genvar k = 0; k < 3; k++) begin : g_lane
      mfd_lane u_lane (.clock, .en(1'b1), .win_new(wn[k]), .win_old(wo[k]),
                       .diff(dl[k]));
   end

   // Tag pipeline matching the lane pipeline, one tag register per lane stage.
   slot_type tag_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) tag_ff[i] <= '0;
      end else begin
         tag_ff[0] <= issuing ? s : '0;
         tag_ff[1] <= tag_ff[0];
         tag_ff[2] <= tag_ff[1];
      end
   end

   // Output FIFO (merging stage) collecting the three lane results.
   result_type fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wp_ff, rp_ff;
   logic push, pop;
   assign push = tag_ff[2].valid;
   assign pop = rsp_tvalid && rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fifo_cnt_ff <= '0; inflight_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + FIFO_AW'(1);
         if (pop) rp_ff <= rp_ff + FIFO_AW'(1);
         fifo_cnt_ff <= fifo_cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
         inflight_ff <= inflight_ff + 3'(issuing) - 3'(push);
      end
   end
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= '{d2: dl[2], d1: dl[1], d0: dl[0], row: tag_ff[2].row,
            col: tag_ff[2].col, frame_end: tag_ff[2].frame_end};
      end
   end

   result_type head;
   assign head = fifo_ff[rp_ff];
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tdata = {2'b0, head.col, head.row, head.d2, head.d1, head.d0};
   assign rsp_tuser = head.frame_end;

`ifndef ASSERT_OFF
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      (FIFO_AW+2)'(fifo_cnt_ff) + (FIFO_AW+2)'(inflight_ff) <= (FIFO_AW+2)'(FIFO_DEPTH))
      else $error("result overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while waiting");
   a_tag_clear: assert property (@(posedge clock) disable iff (reset)
      !issuing |=> !tag_ff[0].valid) else $error("phantom result");
`endif
endmodule
